/* rtl/core/node_table_with_aging_defines.svh */
// assertion macros for the node table
`ifndef NODE_TABLE_WITH_AGING_DEFINES_SVH
`define NODE_TABLE_WITH_AGING_DEFINES_SVH
`define NTA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: label failed");
`define NTA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: label failed");
`endif

/* rtl/core/nta_pkg.sv */
package nta_pkg;
   localparam logic [1:0] CMD_BEAT = 2'd0;
   localparam logic [1:0] CMD_OFF = 2'd1;
   localparam logic [1:0] CMD_SWEEP = 2'd2;
   localparam logic [1:0] CMD_BAD = 2'd3;
   localparam logic [2:0] KIND_INGEST = 3'd0;
   localparam logic [2:0] KIND_OFF = 3'd1;
   localparam logic [2:0] KIND_EVICT = 3'd2;
   localparam logic [2:0] KIND_SWEEP = 3'd3;
   localparam logic [2:0] KIND_IGNORED = 3'd4;
   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_LIMIT = 1'b1;

   typedef enum logic [1:0] {OP_IGNORE, OP_BEAT, OP_OFF, OP_SWEEP} op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] now_ms;
      logic [47:0] node_addr;
      logic [47:0] parent_addr;
      logic [7:0]  node_role;
      logic [15:0] node_layer;
      logic [7:0]  link_rssi;
      logic [31:0] uptime_s;
      logic [7:0]  phase_id;
   } job_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [47:0] result_addr;
      logic        was_new;
      logic        row_changed;
      logic        table_full;
      logic        found;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_READ, ST_CHECK, ST_MOVE_RD, ST_MOVE_WR, ST_EMIT
   } state_type;
endpackage

/* rtl/core/nta_front.sv */
module nta_front import nta_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        table_enable,
   input  logic [1:0]  cmd,
   input  job_type     job_in,
   output logic        job_valid,
   output job_type     job_out,
   input  logic        job_take
);
   job_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, wr_ff;
   job_type j;
   logic acc;

   always_comb begin
      j = job_in;
      if (!table_enable) begin
         j.op = OP_IGNORE;
      end else begin
         case (cmd)
            CMD_BEAT: j.op = OP_BEAT;
            CMD_OFF: j.op = OP_OFF;
            CMD_SWEEP: j.op = OP_SWEEP;
            default: j.op = OP_IGNORE;
         endcase
      end
   end

   assign full = cnt_ff == 2'd2;
   assign acc = push && !full;
   assign job_valid = cnt_ff != 2'd0;
   assign job_out = q_ff[rd_ff];
   assign cnt_in = cnt_ff + {1'b0, acc} - {1'b0, job_take && job_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (acc) wr_ff <= !wr_ff;
         if (job_take && job_valid) rd_ff <= !rd_ff;
      end
      if (acc) q_ff[wr_ff] <= j;
   end
endmodule

/* rtl/core/nta_back.sv */
module nta_back import nta_pkg::*; #(
   parameter int TABLE_ROWS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [23:0] stale_limit,
   input  logic        job_valid,
   input  job_type     job,
   output logic        job_take,
   output logic        out_valid,
   output rsp_type     out_rsp,
   output logic [5:0]  out_count,
   input  logic        out_take
);
   localparam int IW = $clog2(TABLE_ROWS);
   localparam int CW = $clog2(TABLE_ROWS + 1);
   typedef struct packed {
      logic [47:0] addr;
      logic [47:0] parent;
      logic [7:0]  role;
      logic [15:0] layer;
      logic [7:0]  rssi;
      logic [31:0] uptime;
      logic [7:0]  phase;
      logic [31:0] seen;
   } row_type;

   row_type mem [TABLE_ROWS];
   row_type rd_ff;
   logic [IW-1:0] raddr;
   logic re, we;
   logic [IW-1:0] waddr;
   row_type wdata;

   state_type st_ff, st_in;
   job_type job_ff, job_in_r;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] i_ff, i_in;
   rsp_type rsp_ff, rsp_in;
   logic [31:0] age;
   logic i_end;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rd_ff <= mem[raddr];
   end

   assign age = job_ff.now_ms - rd_ff.seen;
   assign i_end = i_ff >= cnt_ff;
   assign out_valid = st_ff == ST_EMIT;
   assign out_rsp = rsp_ff;
   assign out_count = 6'(cnt_ff);

   always_comb begin
      st_in = st_ff;
      job_in_r = job_ff;
      cnt_in = cnt_ff;
      i_in = i_ff;
      rsp_in = rsp_ff;
      job_take = 1'b0;
      re = 1'b0;
      raddr = i_ff[IW-1:0];
      we = 1'b0;
      waddr = i_ff[IW-1:0];
      wdata = rd_ff;
      case (st_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               job_in_r = job;
               i_in = '0;
               rsp_in = '0;
               rsp_in.last = 1'b1;
               if (job.op == OP_IGNORE) begin
                  rsp_in.kind = KIND_IGNORED;
                  st_in = ST_EMIT;
               end else begin
                  st_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (i_end) begin
               rsp_in = '0;
               rsp_in.last = 1'b1;
               rsp_in.result_addr = job_ff.node_addr;
               st_in = ST_EMIT;
               case (job_ff.op)
                  OP_BEAT: begin
                     rsp_in.kind = KIND_INGEST;
                     if (cnt_ff >= CW'(TABLE_ROWS)) begin
                        rsp_in.table_full = 1'b1;
                     end else begin
                        we = 1'b1;
                        wdata = '{job_ff.node_addr, job_ff.parent_addr, job_ff.node_role,
                                  job_ff.node_layer, job_ff.link_rssi, job_ff.uptime_s,
                                  job_ff.phase_id, job_ff.now_ms};
                        cnt_in = cnt_ff + 1'b1;
                        rsp_in.was_new = 1'b1;
                        rsp_in.row_changed = 1'b1;
                     end
                  end
                  OP_OFF: rsp_in.kind = KIND_OFF;
                  default: begin
                     rsp_in.kind = KIND_SWEEP;
                     rsp_in.result_addr = '0;
                  end
               endcase
            end else begin
               re = 1'b1;
               st_in = ST_READ;
            end
         end
         ST_READ: st_in = ST_CHECK;
         ST_CHECK: begin
            st_in = ST_SCAN;
            i_in = i_ff + 1'b1;
            rsp_in = '0;
            case (job_ff.op)
               OP_BEAT: begin
                  if (rd_ff.addr == job_ff.node_addr) begin
                     we = 1'b1;
                     wdata = '{job_ff.node_addr, job_ff.parent_addr, job_ff.node_role,
                               job_ff.node_layer, job_ff.link_rssi, job_ff.uptime_s,
                               job_ff.phase_id, job_ff.now_ms};
                     rsp_in.kind = KIND_INGEST;
                     rsp_in.result_addr = job_ff.node_addr;
                     rsp_in.row_changed = rd_ff.layer != job_ff.node_layer ||
                        rd_ff.parent != job_ff.parent_addr || rd_ff.role != job_ff.node_role;
                     rsp_in.last = 1'b1;
                     st_in = ST_EMIT;
                  end
               end
               OP_OFF: begin
                  if (rd_ff.addr == job_ff.node_addr) begin
                     rsp_in.kind = KIND_OFF;
                     rsp_in.result_addr = job_ff.node_addr;
                     rsp_in.found = 1'b1;
                     rsp_in.last = 1'b1;
                     st_in = ST_MOVE_RD;
                     i_in = i_ff;
                  end
               end
               default: begin
                  if (age > {8'd0, stale_limit}) begin
                     rsp_in.kind = KIND_EVICT;
                     rsp_in.result_addr = rd_ff.addr;
                     st_in = ST_MOVE_RD;
                     i_in = i_ff;
                  end
               end
            endcase
         end
         ST_MOVE_RD: begin
            re = 1'b1;
            raddr = IW'(cnt_ff - 1'b1);
            st_in = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            we = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            st_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_take) begin
               st_in = rsp_ff.last ? ST_IDLE : ST_SCAN;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
      end
      job_ff <= job_in_r;
      i_ff <= i_in;
      rsp_ff <= rsp_in;
   end
endmodule

/* rtl/core/node_table_with_aging.sv */
// Node table with aging: up to TABLE_ROWS rows keyed by a 48-bit address. Requests enter a
// two-deep queue and are run one at a time by a sequencer over a single-port row memory.
// A heartbeat or offline request runs the scan, read and check states per row scanned; a
// sweep does so per kept row and, per evicted row, moves the last row in and waits for its
// result to be popped. All results of a request come out in order, last marking the end.
module node_table_with_aging import nta_pkg::*; #(
   parameter int TABLE_ROWS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_now_ms,
   input  logic [47:0] req_node_addr,
   input  logic [47:0] req_parent_addr,
   input  logic [7:0]  req_node_role,
   input  logic signed [15:0] req_node_layer,
   input  logic signed [7:0]  req_link_rssi,
   input  logic [31:0] req_uptime_s,
   input  logic [7:0]  req_phase_id,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_kind,
   output logic [47:0] rsp_result_addr,
   output logic        rsp_was_new,
   output logic        rsp_row_changed,
   output logic        rsp_table_full,
   output logic        rsp_found,
   output logic [5:0]  rsp_row_count,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);
   logic en_ff;
   logic [23:0] limit_ff;
   job_type jin, jq;
   logic jv, jt, ov;
   rsp_type r;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
         limit_ff <= 24'd15000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE: en_ff <= csr_wdata[0];
            CSR_LIMIT: limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign jin = '{OP_IGNORE, req_now_ms, req_node_addr, req_parent_addr, req_node_role,
                  req_node_layer, req_link_rssi, req_uptime_s, req_phase_id};

   nta_front u_front (.clock, .reset, .push, .full, .table_enable(en_ff), .cmd(req_cmd),
      .job_in(jin), .job_valid(jv), .job_out(jq), .job_take(jt));

   nta_back #(.TABLE_ROWS(TABLE_ROWS)) u_back (.clock, .reset, .stale_limit(limit_ff),
      .job_valid(jv), .job(jq), .job_take(jt), .out_valid(ov), .out_rsp(r),
      .out_count(rsp_row_count), .out_take(pop));

   assign empty = !ov;
   assign rsp_kind = r.kind;
   assign rsp_result_addr = r.result_addr;
   assign rsp_was_new = r.was_new;
   assign rsp_row_changed = r.row_changed;
   assign rsp_table_full = r.table_full;
   assign rsp_found = r.found;
   assign rsp_last = r.last;
endmodule

/* rtl/core/nta_checker.sv */
`include "node_table_with_aging_defines.svh"
module nta_props import nta_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic [2:0] rsp_kind,
   input logic       rsp_last,
   input logic       rsp_was_new,
   input logic       rsp_table_full
);
   `NTA_ASSERT_NEXT(a_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_kind))
   `NTA_ASSERT_IMPL(a_evict_notlast, clock, reset, !empty && rsp_kind == KIND_EVICT, !rsp_last)
   `NTA_ASSERT_IMPL(a_full_notnew, clock, reset, !empty && rsp_table_full, !rsp_was_new)
endmodule

bind node_table_with_aging nta_props u_chk (.clock, .reset, .empty, .pop, .rsp_kind,
   .rsp_last, .rsp_was_new, .rsp_table_full);
